// File: src/most_frequent_pair_select_assert.svh
// assertion macros for the most frequent pair select block
// expects clk and arst_n in the scope where a macro is used
`ifndef MOST_FREQUENT_PAIR_SELECT_ASSERT_SVH
`define MOST_FREQUENT_PAIR_SELECT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MFPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define MFPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/mfps_pkg.sv
// shared types and constants for the most frequent pair select block
// no dependencies
`default_nettype none

package mfps_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF = 32;
	localparam int FIELD_BITS     = 16;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int NUM_RANGES     = 3;
	localparam int RANGE_CNT_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_COUNT = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE0_LOW  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE0_HIGH = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE1_LOW  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE1_HIGH = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE2_LOW  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE2_HIGH = 3'd6;

	typedef struct packed {
		logic                      en;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  data;
	} cfg_wr_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RD_B  = 6'b000100,
		ST_WR_A  = 6'b001000,
		ST_WR_B  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// File: src/mfps_if.sv
// handshake channels for value pairs and chosen results
// depends on mfps_pkg
`default_nettype none

interface mfps_item_if import mfps_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [FIELD_BITS-1:0] first_value;
	logic [FIELD_BITS-1:0] second_value;

	modport source (output valid, output first_value, output second_value, input ready);
	modport sink (input valid, input first_value, input second_value, output ready);
endinterface

interface mfps_result_if import mfps_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [FIELD_BITS-1:0] chosen_value;
	logic                  in_range;

	modport source (output valid, output chosen_value, output in_range, input ready);
	modport sink (input valid, input chosen_value, input in_range, output ready);
endinterface

`default_nettype wire

// File: src/mfps_range_match.sv
// range configuration registers and inclusive range test of the chosen value
// depends on mfps_pkg
`default_nettype none

module mfps_range_match
	import mfps_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_wr_t               cfg_wr,
	input  wire logic [FIELD_BITS-1:0] value,
	output logic                       match
);

	logic [RANGE_CNT_BITS-1:0] range_count_q;
	logic [FIELD_BITS-1:0]     low_q  [NUM_RANGES];
	logic [FIELD_BITS-1:0]     high_q [NUM_RANGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_count_q <= '0;
			for (int r = 0; r < NUM_RANGES; r++) begin
				low_q[r]  <= '0;
				high_q[r] <= '1;
			end
		end else if (cfg_wr.en) begin
			unique case (cfg_wr.index)
				REG_RANGE_COUNT: range_count_q <= cfg_wr.data[RANGE_CNT_BITS-1:0];
				REG_RANGE0_LOW:  low_q[0]      <= cfg_wr.data[FIELD_BITS-1:0];
				REG_RANGE0_HIGH: high_q[0]     <= cfg_wr.data[FIELD_BITS-1:0];
				REG_RANGE1_LOW:  low_q[1]      <= cfg_wr.data[FIELD_BITS-1:0];
				REG_RANGE1_HIGH: high_q[1]     <= cfg_wr.data[FIELD_BITS-1:0];
				REG_RANGE2_LOW:  low_q[2]      <= cfg_wr.data[FIELD_BITS-1:0];
				REG_RANGE2_HIGH: high_q[2]     <= cfg_wr.data[FIELD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// only the first range_count ranges take part
	always_comb begin
		match = 1'b0;
		for (int r = 0; r < NUM_RANGES; r++) begin
			if ((RANGE_CNT_BITS'(r) < range_count_q) && (value >= low_q[r]) &&
					(value <= high_q[r])) begin
				match = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/most_frequent_pair_select.sv
// Flow: a pair passes RD_B, WR_A, WR_B (DONE while the output stalls); its
// result is registered on leaving WR_B or DONE. No new pair until IDLE: two
// reads and up to two writes per pair share one single-port counter memory.
// Reset: range registers take their reset values at once; a clearing pass
// then zeroes all 2**VALUE_BITS counters, one per cycle, with ready held low.
`default_nettype none

module most_frequent_pair_select
	import mfps_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [CFG_INDEX_BITS-1:0] wr_index,
	input  wire logic [CFG_DATA_BITS-1:0]  wr_data,
	mfps_item_if.sink                      in_item,
	mfps_result_if.source                  out_result
);

	localparam int DEPTH = 1 << VALUE_BITS;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   clr_addr_q;
	logic [VALUE_BITS-1:0]   a_q, b_q, pick_q;
	logic [COUNT_BITS-1:0]   ca_q, cb_q, rd_q;
	logic                    out_valid_q;
	logic [FIELD_BITS-1:0]   chosen_q;
	logic                    in_range_q;

	logic [COUNT_BITS-1:0]   mem [DEPTH];
	logic                    mem_we;
	logic [VALUE_BITS-1:0]   mem_addr;
	logic [COUNT_BITS-1:0]   mem_wdata;

	logic [COUNT_BITS-1:0]   inc_base;
	logic [1:0]              inc_amt;
	logic [COUNT_BITS:0]     inc_sum;
	logic [COUNT_BITS-1:0]   inc_sat;

	logic                    accept, out_free, out_load, same;
	logic [VALUE_BITS-1:0]   pick_d;
	logic [FIELD_BITS-1:0]   pick_ext;
	logic                    match;
	cfg_wr_t                 cfg_wr;

	assign accept   = in_item.valid && in_item.ready;
	assign out_free = !out_valid_q || out_result.ready;
	assign out_load = ((state_q == ST_WR_B) || (state_q == ST_DONE)) && out_free;
	assign same     = (a_q == b_q);
	assign in_item.ready = (state_q == ST_IDLE);

	assign out_result.valid        = out_valid_q;
	assign out_result.chosen_value = chosen_q;
	assign out_result.in_range     = in_range_q;

	assign cfg_wr.en    = wr_en;
	assign cfg_wr.index = wr_index;
	assign cfg_wr.data  = wr_data;

	assign pick_ext = FIELD_BITS'(pick_q);

	mfps_range_match u_range (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.value  (pick_ext),
		.match  (match)
	);

	// shared saturating incrementer, first for a then for b
	always_comb begin
		inc_base = (state_q == ST_WR_A) ? ca_q : cb_q;
		inc_amt  = ((state_q == ST_WR_A) && same) ? 2'd2 : 2'd1;
		inc_sum  = {1'b0, inc_base} + (COUNT_BITS + 1)'(inc_amt);
		inc_sat  = inc_sum[COUNT_BITS] ? '1 : inc_sum[COUNT_BITS-1:0];
	end

	// rd_q holds b's count during WR_A
	always_comb begin
		if (ca_q != rd_q) begin
			pick_d = (ca_q > rd_q) ? a_q : b_q;
		end else begin
			pick_d = (a_q < b_q) ? a_q : b_q;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = a_q;
		mem_wdata = inc_sat;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_addr_q;
				mem_wdata = '0;
			end
			ST_IDLE:  mem_addr = in_item.first_value[VALUE_BITS-1:0];
			ST_RD_B:  mem_addr = b_q;
			ST_WR_A: begin
				mem_we   = 1'b1;
				mem_addr = a_q;
			end
			ST_WR_B: begin
				// a pair of equal values was already counted twice
				mem_we   = !same;
				mem_addr = b_q;
			end
			ST_DONE:  mem_addr = b_q;
			default:  mem_addr = a_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= in_item.first_value[VALUE_BITS-1:0];
			b_q <= in_item.second_value[VALUE_BITS-1:0];
		end
		if (state_q == ST_RD_B) begin
			ca_q <= rd_q;
		end
		if (state_q == ST_WR_A) begin
			cb_q   <= rd_q;
			pick_q <= pick_d;
		end
		if (out_load) begin
			chosen_q   <= pick_ext;
			in_range_q <= match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == VALUE_BITS'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD_B;
					end
				end
				ST_RD_B: state_q <= ST_WR_A;
				ST_WR_A: state_q <= ST_WR_B;
				ST_WR_B, ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/mfps_checker.sv
// port-level checks for most_frequent_pair_select, bound to the top level
// depends on most_frequent_pair_select_assert.svh
`default_nettype none

`include "most_frequent_pair_select_assert.svh"

module mfps_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);

	// a waiting result stays until its transfer
	`MFPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transfer")

	// one pair at a time: busy right after a transfer in
	`MFPS_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "pair taken while busy")

	// no result rises in the cycle right after a pair is transferred in
	`MFPS_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "result too early")

endmodule

bind most_frequent_pair_select mfps_checker u_mfps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_item.valid),
	.in_ready  (in_item.ready),
	.out_valid (out_result.valid),
	.out_ready (out_result.ready)
);

`default_nettype wire
